// File: rtl/core/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants of the power meter statistics core.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int SamplesPerAverage = 16;
  localparam int WindowSeconds     = 10;
  localparam int WinPosW           = $clog2(WindowSeconds);
  localparam int WinFillW          = $clog2(WindowSeconds + 1);

  localparam logic [14:0] NO_VALUE   = 15'd32767;
  localparam logic [14:0] POWER_CEIL = 15'd32766;

  // Reciprocal constants for the divides by constants
  localparam int          PwrRecipShift  = 35;
  localparam logic [29:0] PWR_SAT        = 30'd32767000;  // first product that saturates
  localparam logic [25:0] PWR_RECIP      = 26'd34359739;  // ceil(2^35 / 1000)
  localparam int          HourRecipShift = 40;
  localparam logic [31:0] HOUR_SAT       = 32'd235929600; // 65536 * 3600
  localparam logic [28:0] HOUR_RECIP     = 29'd305419897; // ceil(2^40 / 3600)
  localparam int          WinRecipShift  = 26;
  localparam logic [26:0] WinRecip       =
    27'(((64'd1 << WinRecipShift) + 64'(WindowSeconds) - 64'd1) / 64'(WindowSeconds));

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] current_ma;
    logic [14:0] voltage_mv;
  } pms_in_t;

  typedef struct packed {
    logic [14:0] avg_current;
    logic [14:0] min_current;
    logic [14:0] max_current;
    logic [14:0] avg_voltage;
    logic [14:0] min_voltage;
    logic [14:0] max_voltage;
    logic [14:0] avg_power;
    logic [14:0] min_power;
    logic [14:0] max_power;
    logic [14:0] window_capacity;
    logic        window_full;
    logic [15:0] hour_capacity;
  } pms_out_t;

endpackage

// File: rtl/core/power_meter_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_meter_statistics_core
// Current/voltage/power min, max, batch average, window and hourly totals.
// ----------------------------------------------------------------------------
// One transaction at a time: a two-entry input queue decouples the source
// from the engine. A tick, reset or unused opcode runs the window, hour and
// output steps; a sample first computes power and tracks the values, and a
// sample closing a batch also runs three average divides on the shared
// serial divider. A result not yet popped holds the engine in its last step.
// Each transaction yields one result showing the state after it.
module power_meter_statistics_core import pms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  pms_in_t  in_data,
  output logic     in_full,
  output logic     out_empty,
  input  logic     out_pop,
  output pms_out_t out_data
);

  logic    q_empty, q_pop;
  pms_in_t q_data;

  pms_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_push), .wr_data(in_data), .full(in_full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  pms_engine u_engine (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

endmodule

// File: rtl/core/pms_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_fifo
// Two-entry queue between the front end and the statistics engine.
// ----------------------------------------------------------------------------
module pms_fifo import pms_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  pms_in_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output pms_in_t rd_data,
  output logic    empty
);

  pms_in_t    mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wptr_r] <= wr_data;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en && !full) wptr_r <= ~wptr_r;
      if (rd_en && !empty) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
    end
  end

endmodule

// File: rtl/core/pms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module pms_div import pms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] dvs_r;
  logic [5:0]  cnt_r;
  logic [16:0] trial;

  assign busy     = (cnt_r != 6'd0);
  assign quotient = q_r;
  assign trial    = {rem_r[15:0], q_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd32;
      q_r   <= dividend;
      rem_r <= 17'd0;
      dvs_r <= divisor;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= trial - {1'b0, dvs_r};
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/pms_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_engine
// Back end: runs one transaction at a time through a sequencer; power, window
// average and hourly total use reciprocal multiplies, batch averages share
// one serial divider.
// ----------------------------------------------------------------------------
module pms_engine import pms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  pms_in_t  q_data,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output pms_out_t out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PWR  = 4'd1;
  localparam logic [3:0] S_PWRW = 4'd2;
  localparam logic [3:0] S_TRK  = 4'd3;
  localparam logic [3:0] S_AVG  = 4'd4;
  localparam logic [3:0] S_AVGW = 4'd5;
  localparam logic [3:0] S_WIN  = 4'd6;
  localparam logic [3:0] S_HR   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]  state_r;
  pms_in_t     item_r;
  logic [29:0] prod_r;
  logic [14:0] pwr_r;
  logic [1:0]  ch_r;
  logic [7:0]  bidx_r;
  logic [23:0] bsum_r [3];
  logic [7:0]  bcnt_r [3];
  logic [14:0] avg_r [3], min_r [3], max_r [3];
  logic [14:0] ring_r [WindowSeconds];
  logic [WinPosW-1:0]  wpos_r;
  logic [19:0] wsum_r;
  logic [WinFillW-1:0] wfill_r;
  logic [31:0] total_r;
  logic [14:0] wcap_r;
  logic [15:0] hour_r;
  logic        ovalid_r;
  pms_out_t    out_r;

  logic        div_start, div_busy;
  logic [31:0] div_a, div_q;
  logic [15:0] div_b;
  logic [14:0] v [3];
  logic [WinPosW-1:0] npos;
  logic [50:0] pwr_mul;
  logic [46:0] win_mul;
  logic [56:0] hour_mul;

  pms_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !ovalid_r;
  assign out_data  = out_r;
  assign v[0] = item_r.current_ma;
  assign v[1] = item_r.voltage_mv;
  assign v[2] = pwr_r;
  assign npos = (wpos_r == WinPosW'(WindowSeconds - 1)) ? '0 : wpos_r + 1'b1;

  // Exact for the operand ranges that reach them
  assign pwr_mul  = 51'(prod_r[24:0]) * 51'(PWR_RECIP);
  assign win_mul  = 47'(wsum_r) * 47'(WinRecip);
  assign hour_mul = 57'(total_r[27:0]) * 57'(HOUR_RECIP);

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = 16'd1;
    unique case (state_r)
      S_AVG: begin
        div_start = 1'b1;
        div_a     = {8'd0, bsum_r[ch_r]};
        div_b     = {8'd0, bcnt_r[ch_r]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      bidx_r   <= '0;
      wpos_r   <= '0;
      wsum_r   <= '0;
      wfill_r  <= '0;
      total_r  <= '0;
      wcap_r   <= '0;
      hour_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        bsum_r[i] <= '0;
        bcnt_r[i] <= '0;
        avg_r[i]  <= NO_VALUE;
        min_r[i]  <= NO_VALUE;
        max_r[i]  <= NO_VALUE;
      end
      for (int i = 0; i < WindowSeconds; i++) ring_r[i] <= '0;
    end else begin
      if (out_pop && ovalid_r && state_r != S_OUT) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (!q_empty) begin
          item_r <= q_data;
          unique case (q_data.opcode)
            OP_SAMPLE: state_r <= S_PWR;
            OP_TICK: begin
              if (avg_r[0] != NO_VALUE) begin
                total_r <= (total_r > 32'hFFFF_FFFF - {17'd0, avg_r[0]}) ?
                           32'hFFFF_FFFF : total_r + {17'd0, avg_r[0]};
                wpos_r  <= npos;
                wsum_r  <= wsum_r + {5'd0, avg_r[0]} - {5'd0, ring_r[npos]};
                ring_r[npos] <= avg_r[0];
                if (wfill_r < WinFillW'(WindowSeconds)) wfill_r <= wfill_r + 1'b1;
              end
              state_r <= S_WIN;
            end
            OP_RESET: begin
              for (int i = 0; i < 3; i++) begin
                min_r[i] <= avg_r[i];
                max_r[i] <= avg_r[i];
              end
              total_r <= '0;
              state_r <= S_WIN;
            end
            default: state_r <= S_WIN;
          endcase
        end
        S_PWR: begin
          prod_r  <= 30'(item_r.current_ma) * 30'(item_r.voltage_mv);
          state_r <= S_PWRW;
        end
        S_PWRW: begin
          if (item_r.current_ma == NO_VALUE || item_r.voltage_mv == NO_VALUE)
            pwr_r <= NO_VALUE;
          else if (prod_r >= PWR_SAT)
            pwr_r <= POWER_CEIL;
          else
            pwr_r <= pwr_mul[PwrRecipShift +: 15];
          state_r <= S_TRK;
        end
        S_TRK: begin
          for (int i = 0; i < 3; i++) begin
            if (v[i] != NO_VALUE) begin
              if (min_r[i] == NO_VALUE || v[i] < min_r[i]) min_r[i] <= v[i];
              if (max_r[i] == NO_VALUE || v[i] > max_r[i]) max_r[i] <= v[i];
              bsum_r[i] <= bsum_r[i] + {9'd0, v[i]};
              bcnt_r[i] <= bcnt_r[i] + 8'd1;
            end
          end
          ch_r <= 2'd0;
          if (bidx_r + 8'd1 >= 8'(SamplesPerAverage)) begin
            bidx_r  <= '0;
            state_r <= S_AVG;
          end else begin
            bidx_r  <= bidx_r + 8'd1;
            state_r <= S_WIN;
          end
        end
        S_AVG: state_r <= S_AVGW;
        S_AVGW: if (!div_busy) begin
          if (bcnt_r[ch_r] == 8'd0) avg_r[ch_r] <= NO_VALUE;
          else avg_r[ch_r] <= (div_q > {17'd0, POWER_CEIL}) ? POWER_CEIL : div_q[14:0];
          bsum_r[ch_r] <= '0;
          bcnt_r[ch_r] <= '0;
          if (ch_r == 2'd2) state_r <= S_WIN;
          else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_AVG;
          end
        end
        S_WIN: begin
          wcap_r  <= win_mul[WinRecipShift +: 15];
          state_r <= S_HR;
        end
        S_HR: begin
          hour_r  <= (total_r >= HOUR_SAT) ? 16'hFFFF : hour_mul[HourRecipShift +: 16];
          state_r <= S_OUT;
        end
        S_OUT: if (!ovalid_r || out_pop) begin
          ovalid_r <= 1'b1;
          out_r.avg_current <= avg_r[0];
          out_r.min_current <= min_r[0];
          out_r.max_current <= max_r[0];
          out_r.avg_voltage <= avg_r[1];
          out_r.min_voltage <= min_r[1];
          out_r.max_voltage <= max_r[1];
          out_r.avg_power   <= avg_r[2];
          out_r.min_power   <= min_r[2];
          out_r.max_power   <= max_r[2];
          out_r.window_full <= (wfill_r >= WinFillW'(WindowSeconds));
          out_r.window_capacity <= (wfill_r >= WinFillW'(WindowSeconds)) ? wcap_r : '0;
          out_r.hour_capacity   <= hour_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop outside idle");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_pop) |=> ovalid_r && $stable(out_r)) else $error("result lost");
`endif

endmodule

// File: test/power_meter_statistics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_meter_statistics_checker
// Watches both queue channels of the statistics core, predicts each result
// from the accepted input transactions and compares it field by field.
// ----------------------------------------------------------------------------
module power_meter_statistics_checker import pms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  pms_in_t  in_data,
  input  logic     in_full,
  input  logic     out_empty,
  input  logic     out_pop,
  input  pms_out_t out_data,
  output int       fail_count,
  output int       pending
);

  logic [7:0]  batch_idx;
  logic [23:0] sums [3];
  logic [7:0]  counts [3];
  logic [14:0] avgs [3];
  logic [14:0] mins [3];
  logic [14:0] maxs [3];
  logic [14:0] ring [WindowSeconds];
  int          wpos;
  logic [19:0] wsum;
  int          wfill;
  logic [31:0] total;

  pms_out_t expected_stats[$];

  initial fail_count = 0;

  function automatic void track(int ch, logic [14:0] v);
    if (v == NO_VALUE) return;
    if (mins[ch] == NO_VALUE || v < mins[ch]) mins[ch] = v;
    if (maxs[ch] == NO_VALUE || v > maxs[ch]) maxs[ch] = v;
    sums[ch] = sums[ch] + 24'(v);
    counts[ch] = counts[ch] + 8'd1;
  endfunction

  function automatic pms_out_t update_stats(pms_in_t t);
    pms_out_t r;
    logic [31:0] prod;
    logic [14:0] pwr;
    logic [31:0] a;
    logic [31:0] hour;
    pwr = NO_VALUE;
    case (t.opcode)
      OP_SAMPLE: begin
        if (t.current_ma != NO_VALUE && t.voltage_mv != NO_VALUE) begin
          prod = (32'(t.current_ma) * 32'(t.voltage_mv)) / 1000;
          pwr = (prod > 32'(POWER_CEIL)) ? POWER_CEIL : prod[14:0];
        end
        track(0, t.current_ma);
        track(1, t.voltage_mv);
        track(2, pwr);
        batch_idx = batch_idx + 8'd1;
        if (batch_idx >= SamplesPerAverage) begin
          for (int ch = 0; ch < 3; ch++) begin
            if (counts[ch] == 0) avgs[ch] = NO_VALUE;
            else begin
              a = 32'(sums[ch]) / 32'(counts[ch]);
              avgs[ch] = (a > 32'(POWER_CEIL)) ? POWER_CEIL : a[14:0];
            end
            sums[ch] = '0;
            counts[ch] = '0;
          end
          batch_idx = '0;
        end
      end
      OP_TICK: begin
        if (avgs[0] != NO_VALUE) begin
          a = 32'(avgs[0]);
          total = (total > 32'hFFFF_FFFF - a) ? 32'hFFFF_FFFF : total + a;
          wpos = (wpos + 1) % WindowSeconds;
          wsum = wsum + 20'(avgs[0]) - 20'(ring[wpos]);
          ring[wpos] = avgs[0];
          if (wfill < WindowSeconds) wfill++;
        end
      end
      OP_RESET: begin
        for (int ch = 0; ch < 3; ch++) begin
          mins[ch] = avgs[ch];
          maxs[ch] = avgs[ch];
        end
        total = '0;
      end
      default: ;
    endcase
    r.avg_current = avgs[0]; r.min_current = mins[0]; r.max_current = maxs[0];
    r.avg_voltage = avgs[1]; r.min_voltage = mins[1]; r.max_voltage = maxs[1];
    r.avg_power = avgs[2]; r.min_power = mins[2]; r.max_power = maxs[2];
    if (wfill >= WindowSeconds) begin
      r.window_capacity = 15'(wsum / WindowSeconds);
      r.window_full = 1'b1;
    end else begin
      r.window_capacity = '0;
      r.window_full = 1'b0;
    end
    hour = total / 3600;
    r.hour_capacity = (hour > 32'hFFFF) ? 16'hFFFF : hour[15:0];
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pms_out_t e;
    if (!rst_n) begin
      wpos = 0; wsum = '0; wfill = 0; total = '0;
      for (int ch = 0; ch < 3; ch++) begin
        sums[ch] = '0; counts[ch] = '0;
        avgs[ch] = NO_VALUE; mins[ch] = NO_VALUE; maxs[ch] = NO_VALUE;
      end
      for (int i = 0; i < WindowSeconds; i++) ring[i] = '0;
      batch_idx = '0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_stats.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          e = expected_stats.pop_front();
          compare_field("avg_current", e.avg_current, out_data.avg_current);
          compare_field("min_current", e.min_current, out_data.min_current);
          compare_field("max_current", e.max_current, out_data.max_current);
          compare_field("avg_voltage", e.avg_voltage, out_data.avg_voltage);
          compare_field("min_voltage", e.min_voltage, out_data.min_voltage);
          compare_field("max_voltage", e.max_voltage, out_data.max_voltage);
          compare_field("avg_power", e.avg_power, out_data.avg_power);
          compare_field("min_power", e.min_power, out_data.min_power);
          compare_field("max_power", e.max_power, out_data.max_power);
          compare_field("window_capacity", e.window_capacity,
                        out_data.window_capacity);
          compare_field("window_full", e.window_full, out_data.window_full);
          compare_field("hour_capacity", e.hour_capacity, out_data.hour_capacity);
        end
      end
      if (in_push && !in_full) expected_stats.push_back(update_stats(in_data));
    end
    pending = expected_stats.size();
  end

endmodule

// File: test/power_meter_statistics_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_meter_statistics_core_tb
// Drives samples, ticks, statistic resets and unused opcodes into the core with random
// gaps and result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module power_meter_statistics_core_tb;
  import pms_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_push;
  pms_in_t  in_data;
  logic     in_full;
  logic     out_empty;
  logic     out_pop;
  pms_out_t out_data;
  int       fail_count;
  int       pending;
  logic     calm;
  logic     hold_results;

  power_meter_statistics_core uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );

  power_meter_statistics_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("*** FAILED ***");
    $finish;
  end

  // Consumer: random stalls, plus one long hold-off to fill the input queue.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) out_pop <= 1'b0;
      else out_pop <= calm || ($urandom_range(99) >= 23);
    end
  end

  function automatic logic [14:0] rand_value();
    case ($urandom_range(9))
      0: return NO_VALUE;
      1: return 15'd0;
      2: return 15'($urandom_range(32766, 30000));
      3: return 15'($urandom_range(32766));
      default: return 15'($urandom_range(6000));
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [14:0] cur, logic [14:0] vol);
    in_push <= 1'b1;
    in_data <= '{opcode: op, current_ma: cur, voltage_mv: vol};
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 23) begin
        in_push <= 1'b0;
        in_data <= '{opcode: 2'($urandom), current_ma: 15'($urandom),
                     voltage_mv: 15'($urandom)};
        @(negedge clk);
      end
    end
  endtask

  initial begin
    int r;
    in_push = 1'b0;
    in_data = '0;
    calm = 1'b0;
    hold_results = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-state ops, extremes, saturating power, invalid values.
    send(OP_TICK, 15'd0, 15'd0);
    send(OP_RESET, 15'd0, 15'd0);
    send(OP_NONE, 15'h7FFF, 15'h7FFF);
    send(OP_SAMPLE, NO_VALUE, 15'd5000);
    send(OP_SAMPLE, 15'd100, NO_VALUE);
    send(OP_SAMPLE, 15'd32766, 15'd32766);
    send(OP_SAMPLE, 15'd0, 15'd0);
    send(OP_SAMPLE, NO_VALUE, NO_VALUE);
    for (int i = 0; i < 8; i++) send(OP_SAMPLE, 15'd1000 + 15'(i), 15'd2000);
    send(OP_TICK, 15'd0, 15'd0);
    send(OP_RESET, 15'd0, 15'd0);
    // A batch's worth of invalid samples; it straddles a batch boundary.
    for (int i = 0; i < SamplesPerAverage; i++) send(OP_SAMPLE, NO_VALUE, NO_VALUE);
    send(OP_TICK, 15'd0, 15'd0);

    // Long result stall with the sender pushing into a full queue.
    fork
      begin
        hold_results = 1'b1;
        repeat (600) @(posedge clk);
        hold_results = 1'b0;
      end
      for (int i = 0; i < 6; i++) send(OP_SAMPLE, rand_value(), rand_value());
    join

    for (int n = 0; n < 1050; n++) begin
      calm = (n >= 400 && n < 550);
      r = $urandom_range(99);
      if (r < 70) send(OP_SAMPLE, rand_value(), rand_value());
      else if (r < 93) send(OP_TICK, 15'($urandom), 15'($urandom));
      else if (r < 98) send(OP_RESET, 15'($urandom), 15'($urandom));
      else send(OP_NONE, 15'($urandom), 15'($urandom));
    end
    in_push <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
